### sv/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// shared types, constants and helpers of the keypad code lock stepper
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int CODE_DIGITS       = 6;
  localparam int TICK_COUNTER_BITS = 22;

  localparam int CODE_W  = 24;
  localparam int DEB_W   = 16;
  localparam int PHASE_W = 16;
  localparam int STEP_W  = 8;
  localparam int RPT_W   = 22;
  localparam int CHAR_W  = 7;

  // entry buffer index, wide enough for CODE_DIGITS-1
  localparam int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  typedef logic [TICK_COUNTER_BITS-1:0] tick_t;
  typedef logic [3:0]                   digit_t;
  typedef digit_t [CODE_DIGITS-1:0]     digit_vec_t;

  localparam tick_t TICK_MAX = tick_t'((64'd1 << TICK_COUNTER_BITS) - 64'd1);

  // register indexes on the config port
  localparam logic [2:0] REG_UNLOCK   = 3'd0;
  localparam logic [2:0] REG_DEBUG    = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE = 3'd2;
  localparam logic [2:0] REG_PHASE    = 3'd3;
  localparam logic [2:0] REG_STEPS    = 3'd4;
  localparam logic [2:0] REG_REPEAT   = 3'd5;

  // code compare result
  typedef struct packed {
    logic unlock;
    logic debug;
  } kcl_match_t;

  // saturate a wait to what the tick counter can hold
  function automatic tick_t clamp_wait(input logic [31:0] t);
    logic [31:0] lim;
    lim = 32'(TICK_MAX);
    if (t > lim) return TICK_MAX;
    return tick_t'(t);
  endfunction

  // 4x4 keypad character map
  function automatic logic [CHAR_W-1:0] key_ascii(input logic [3:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = 7'h31;
      4'd1:    c = 7'h32;
      4'd2:    c = 7'h33;
      4'd3:    c = 7'h41;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h42;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h38;
      4'd10:   c = 7'h39;
      4'd11:   c = 7'h43;
      4'd12:   c = 7'h2A;
      4'd13:   c = 7'h30;
      4'd14:   c = 7'h23;
      default: c = 7'h44;
    endcase
    return c;
  endfunction

  // two-phase-on coil update: set one coil of a pair, clear its partner
  function automatic logic [3:0] apply_phase(input logic [3:0] coil, input logic [1:0] ph);
    logic [3:0] c;
    case (ph)
      2'd0:    c = (coil | 4'b0001) & ~4'b0010;
      2'd1:    c = (coil | 4'b0100) & ~4'b1000;
      2'd2:    c = (coil | 4'b0010) & ~4'b0001;
      default: c = (coil | 4'b1000) & ~4'b0100;
    endcase
    return c;
  endfunction

endpackage

### sv/keypad_code_lock_stepper.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_stepper
// 4x4 keypad scanner with code entry, debug toggle and stepper run
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready   column_lines (one keypad tick)
//  out_     output     out_valid / out_ready row, coil, key and status fields
//  cfg      apb        psel/penable/pwrite   six code and timing registers
//
//  one transaction in, one transaction out, one per clock cycle unless a held result stalls
//  in_ready: the result register is the only stage: a tick is decoded in the cycle it
//  is accepted and its result is shown in the next
//  in_ready stays high while the result register is empty or being taken
//  rst_n is synchronous, active low; registers return to their defaults
// ----------------------------------------------------------------------------
module keypad_code_lock_stepper
  import kcl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  // keypad tick in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_column_lines,

  // result out
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_row_drive,
  output logic [3:0]          out_coil_pattern,
  output logic                out_key_strobe,
  output logic [6:0]          out_key_char,
  output logic [2:0]          out_digits_held,
  output logic                out_motor_running,
  output logic                out_debug_on,
  output logic [7:0]          out_steps_done,
  output logic [3:0]          out_scan_position,

  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEBOUNCE,
    ST_SCAN,
    ST_RUN,
    ST_REPEAT
  } state_t;

  // config registers
  logic [CODE_W-1:0]  unlock_code_r;
  logic [CODE_W-1:0]  debug_code_r;
  logic [DEB_W-1:0]   debounce_r;
  logic [PHASE_W-1:0] phase_r;
  logic [STEP_W-1:0]  step_count_r;
  logic [RPT_W-1:0]   repeat_r;

  // control state
  state_t             state_r, state_nxt;
  tick_t              tick_r, tick_nxt;
  logic [1:0]         col_r, col_nxt;
  logic [1:0]         row_r, row_nxt;
  logic [1:0]         rut_r, rut_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               debug_r, debug_nxt;
  logic [3:0]         coil_r, coil_nxt;
  logic [1:0]         cphase_r, cphase_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;

  // entry buffer, no reset: never read before written
  digit_t             digits_r [CODE_DIGITS];
  logic               dig_we;
  digit_t             key_idx;
  digit_vec_t         cmp_digits;
  kcl_match_t         match;

  // result register
  logic               out_valid_r;
  logic [3:0]         rows_r, rows_nxt;
  logic               strobe_r, strobe_nxt;

  logic               in_fire;
  logic               cfg_wr;
  logic [2:0]         reg_idx;

  tick_t              tick_inc;
  tick_t              deb_wait;
  tick_t              rpt_wait;
  tick_t              hold_wait;
  logic [STEP_W-1:0]  steps_inc;
  logic [1:0]         low_col;
  logic [1:0]         scan_row;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_code_r <= CODE_W'(6636048);
      debug_code_r  <= CODE_W'(74838);
      debounce_r    <= DEB_W'(1000);
      phase_r       <= PHASE_W'(8999);
      step_count_r  <= STEP_W'(22);
      repeat_r      <= RPT_W'(1900000);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_UNLOCK:   unlock_code_r <= pwdata[CODE_W-1:0];
        REG_DEBUG:    debug_code_r  <= pwdata[CODE_W-1:0];
        REG_DEBOUNCE: debounce_r    <= pwdata[DEB_W-1:0];
        REG_PHASE:    phase_r       <= pwdata[PHASE_W-1:0];
        REG_STEPS:    step_count_r  <= pwdata[STEP_W-1:0];
        REG_REPEAT:   repeat_r      <= pwdata[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_UNLOCK:   prdata = 32'(unlock_code_r);
      REG_DEBUG:    prdata = 32'(debug_code_r);
      REG_DEBOUNCE: prdata = 32'(debounce_r);
      REG_PHASE:    prdata = 32'(phase_r);
      REG_STEPS:    prdata = 32'(step_count_r);
      REG_REPEAT:   prdata = 32'(repeat_r);
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------- waits and helpers ----------------
  assign deb_wait  = clamp_wait(32'(debounce_r));
  assign rpt_wait  = clamp_wait(32'(repeat_r));
  assign hold_wait = clamp_wait((phase_r == '0) ? 32'd1 : 32'(phase_r));
  assign tick_inc  = tick_r + tick_t'(1);
  assign steps_inc = steps_r + STEP_W'(1);

  // highest-numbered low column wins
  always_comb begin
    low_col = col_r;
    for (int i = 0; i < 4; i++) begin
      if (!in_column_lines[i]) low_col = 2'(i);
    end
  end

  // test the latched column against the row driven now; no hit keeps the old row
  assign scan_row = (!in_column_lines[col_r]) ? rut_r : row_r;

  // key index uses the row as updated on this scan tick
  assign key_idx = {scan_row, col_r};

  // compare vector: the last slot takes the key arriving now
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      cmp_digits[i] = digits_r[i];
    end
    cmp_digits[CODE_DIGITS-1] = key_idx;
  end

  kcl_code_match u_match (
    .digits      (cmp_digits),
    .unlock_code (unlock_code_r),
    .debug_code  (debug_code_r),
    .match       (match)
  );

  // ---------------- next-state logic for one tick ----------------
  always_comb begin
    state_nxt  = state_r;
    tick_nxt   = tick_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rut_nxt    = rut_r;
    count_nxt  = count_r;
    debug_nxt  = debug_r;
    coil_nxt   = coil_r;
    cphase_nxt = cphase_r;
    steps_nxt  = steps_r;
    char_nxt   = char_r;
    rows_nxt   = 4'hF;
    strobe_nxt = 1'b0;
    dig_we     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        rows_nxt = 4'h0;
        if (in_column_lines != 4'hF) begin
          col_nxt   = low_col;
          tick_nxt  = '0;
          rut_nxt   = 2'd0;
          state_nxt = (deb_wait == '0) ? ST_SCAN : ST_DEBOUNCE;
        end
      end

      ST_DEBOUNCE: begin
        rows_nxt = 4'h0;
        tick_nxt = tick_inc;
        if (tick_inc >= deb_wait) begin
          tick_nxt  = '0;
          rut_nxt   = 2'd0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        rows_nxt = ~(4'b0001 << rut_r);
        row_nxt  = scan_row;
        if (rut_r == 2'd3) begin
          rut_nxt    = 2'd0;
          strobe_nxt = 1'b1;
          char_nxt   = key_ascii(key_idx);
          dig_we     = 1'b1;
          tick_nxt   = '0;
          state_nxt  = (rpt_wait == '0) ? ST_IDLE : ST_REPEAT;
          if (count_r == CNT_W'(CODE_DIGITS - 1)) begin
            // buffer full: compare and clear
            count_nxt = '0;
            if (!match.unlock && match.debug) debug_nxt = !debug_r;
            if (match.unlock) begin
              steps_nxt = '0;
              if (step_count_r != '0) begin
                state_nxt  = ST_RUN;
                cphase_nxt = 2'd0;
                coil_nxt   = apply_phase(coil_r, 2'd0);
              end
            end
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end else begin
          rut_nxt = rut_r + 2'd1;
        end
      end

      ST_RUN: begin
        tick_nxt = tick_inc;
        if (tick_inc >= hold_wait) begin
          tick_nxt = '0;
          if (cphase_r == 2'd3) begin
            steps_nxt  = steps_inc;
            cphase_nxt = 2'd0;
            if (steps_inc >= step_count_r) begin
              // run done, coils keep their pattern
              state_nxt = (rpt_wait == '0) ? ST_IDLE : ST_REPEAT;
            end else begin
              coil_nxt = apply_phase(coil_r, 2'd0);
            end
          end else begin
            cphase_nxt = cphase_r + 2'd1;
            coil_nxt   = apply_phase(coil_r, cphase_r + 2'd1);
          end
        end
      end

      ST_REPEAT: begin
        tick_nxt = tick_inc;
        if (tick_inc >= rpt_wait) begin
          tick_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        rows_nxt  = 4'h0;
        tick_nxt  = '0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------- state and result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      col_r       <= 2'd0;
      row_r       <= 2'd0;
      rut_r       <= 2'd0;
      count_r     <= '0;
      debug_r     <= 1'b0;
      coil_r      <= 4'h0;
      cphase_r    <= 2'd0;
      steps_r     <= '0;
      char_r      <= '0;
      rows_r      <= 4'h0;
      strobe_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        tick_r      <= tick_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        rut_r       <= rut_nxt;
        count_r     <= count_nxt;
        debug_r     <= debug_nxt;
        coil_r      <= coil_nxt;
        cphase_r    <= cphase_nxt;
        steps_r     <= steps_nxt;
        char_r      <= char_nxt;
        rows_r      <= rows_nxt;
        strobe_r    <= strobe_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // entry buffer write, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && dig_we) digits_r[count_r] <= key_idx;
  end

  // ---------------- result fields ----------------
  // status fields come straight from the state updated by the last tick
  assign out_valid         = out_valid_r;
  assign out_row_drive     = rows_r;
  assign out_coil_pattern  = coil_r;
  assign out_key_strobe    = strobe_r;
  assign out_key_char      = char_r;
  assign out_digits_held   = 3'(count_r);
  assign out_motor_running = (state_r == ST_RUN);
  assign out_debug_on      = debug_r;
  assign out_steps_done    = steps_r;
  assign out_scan_position = {row_r, col_r};

endmodule

### sv/kcl_code_match.sv
// ----------------------------------------------------------------------------
// kcl_code_match
// compares a full entry buffer against the unlock and debug codes
// ----------------------------------------------------------------------------
module kcl_code_match
  import kcl_pkg::*;
(
  input  digit_vec_t          digits,
  input  logic [CODE_W-1:0]   unlock_code,
  input  logic [CODE_W-1:0]   debug_code,
  output kcl_match_t          match
);

  logic [CODE_DIGITS-1:0] hit_unlock;
  logic [CODE_DIGITS-1:0] hit_debug;

  for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_digit
    digit_t u_dig;
    digit_t d_dig;
    if (4 * i + 3 < CODE_W) begin : g_in
      assign u_dig = unlock_code[4*i +: 4];
      assign d_dig = debug_code[4*i +: 4];
    end else begin : g_out
      assign u_dig = 4'd0;
      assign d_dig = 4'd0;
    end
    // a digit matching unlock never counts toward debug
    assign hit_unlock[i] = (digits[i] == u_dig);
    assign hit_debug[i]  = (digits[i] != u_dig) && (digits[i] == d_dig);
  end

  assign match.unlock = &hit_unlock;
  assign match.debug  = &hit_debug;

endmodule
